// ===== hw/rtl/cid_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package cid_pkg;

  // Table depth default and index width of a cell (up to 256 cells)
  localparam int TABLE_ENTRIES_DEFAULT = 64;
  localparam int CELL_IDX_W = 8;

  // Field widths
  localparam int ID_W   = 11;
  localparam int TIME_W = 32;
  localparam int SLOT_W = 6;
  localparam int CNT_W  = 8;
  localparam int RES_W  = 48;

  // Item kinds carried in s_tuser
  localparam logic OP_FRAME = 1'b0;
  localparam logic OP_LOAD  = 1'b1;

  // Short interval count limits
  localparam logic [CNT_W-1:0] ALERT_LIMIT_RESET = 8'd10;
  localparam logic [CNT_W-1:0] COUNT_MAX         = 8'hFF;

  // Search token handed from cell to cell, with the result built on the way
  typedef struct packed {
    logic              valid;
    logic              op;
    logic [ID_W-1:0]   can_id;
    logic [TIME_W-1:0] timestamp;
    logic [SLOT_W-1:0] entry_slot;
    logic [TIME_W-1:0] min_interval;
    logic              matched;
    logic [SLOT_W-1:0] hit_slot;
    logic [TIME_W-1:0] interval;
    logic [CNT_W-1:0]  short_count;
  } cid_token_t;

endpackage
`default_nettype wire

// ===== hw/rtl/cid_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
module cid_cell import cid_pkg::*; #(
  parameter int CELL_INDEX = 0
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire cid_token_t tok_in,
  output cid_token_t      tok_out
);

  localparam logic [CELL_IDX_W-1:0] IDX = CELL_IDX_W'(CELL_INDEX);

  // Entry state held by this cell
  logic [ID_W-1:0]   ident;
  logic [TIME_W-1:0] min_interval;
  logic [TIME_W-1:0] prev_arrival;
  logic              loaded;
  logic              seen;
  logic [CNT_W-1:0]  short_count;

  logic              load_hit;
  logic              frame_hit;
  logic [TIME_W-1:0] diff;
  logic [CNT_W-1:0]  count_upd;
  cid_token_t        tok_next;

  // Match decode: first loaded entry in index order claims the frame
  always_comb begin
    load_hit  = tok_in.valid && (tok_in.op == OP_LOAD) &&
                ({{(CELL_IDX_W-SLOT_W){1'b0}}, tok_in.entry_slot} == IDX);
    frame_hit = tok_in.valid && (tok_in.op == OP_FRAME) && !tok_in.matched &&
                loaded && (ident == tok_in.can_id);
  end

  // Wrapped interval and count update
  always_comb begin
    diff = tok_in.timestamp - prev_arrival;
    if (diff < min_interval) begin
      count_upd = (short_count == COUNT_MAX) ? short_count : short_count + 8'd1;
    end else begin
      count_upd = '0;
    end
  end

  // Token passed on with this cell's result if it matched
  always_comb begin
    tok_next = tok_in;
    if (frame_hit) begin
      tok_next.matched     = 1'b1;
      tok_next.hit_slot    = SLOT_W'(CELL_INDEX);
      tok_next.interval    = seen ? diff : '0;
      tok_next.short_count = seen ? count_upd : short_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else begin
      tok_out.valid <= tok_next.valid;
    end
    tok_out.op           <= tok_next.op;
    tok_out.can_id       <= tok_next.can_id;
    tok_out.timestamp    <= tok_next.timestamp;
    tok_out.entry_slot   <= tok_next.entry_slot;
    tok_out.min_interval <= tok_next.min_interval;
    tok_out.matched      <= tok_next.matched;
    tok_out.hit_slot     <= tok_next.hit_slot;
    tok_out.interval     <= tok_next.interval;
    tok_out.short_count  <= tok_next.short_count;
  end

  // Entry control state
  always_ff @(posedge clk) begin
    if (rst) begin
      loaded      <= 1'b0;
      seen        <= 1'b0;
      short_count <= '0;
    end else if (load_hit) begin
      loaded      <= 1'b1;
      seen        <= 1'b0;
      short_count <= '0;
    end else if (frame_hit) begin
      seen <= 1'b1;
      if (seen) begin
        short_count <= count_upd;
      end
    end
  end

  // Entry payload
  always_ff @(posedge clk) begin
    if (load_hit) begin
      ident        <= tok_in.can_id;
      min_interval <= tok_in.min_interval;
    end
    if (frame_hit) begin
      prev_arrival <= tok_in.timestamp;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/cid_outq.sv =====
`timescale 1ns / 1ps
`default_nettype none
module cid_outq import cid_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire cid_token_t       tok_in,
  input  wire logic [CNT_W-1:0] alert_limit,
  output logic                  space,
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  // matched, hit_slot[5:0], interval[31:0], short_count[7:0], alert
  output logic [RES_W-1:0]      m_tdata
);

  logic [RES_W-1:0] q0;
  logic [RES_W-1:0] q1;
  logic [1:0]       count;
  logic [RES_W-1:0] res;
  logic             push;
  logic             pop;
  logic             alert;

  // Pack the result; a load leaves every field zero
  always_comb begin
    alert = tok_in.matched && (tok_in.short_count > alert_limit);
    res   = {alert, tok_in.short_count, tok_in.interval, tok_in.hit_slot, tok_in.matched};
    push  = tok_in.valid;
    pop   = m_tvalid && m_tready;
  end

  assign m_tvalid = (count != 2'd0);
  assign m_tdata  = q0;
  assign space    = (count != 2'd2);

  // Two-deep result queue
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push && ((count == 2'd0) || ((count == 2'd1) && pop))) begin
      q0 <= res;
    end else if (pop && (count == 2'd2)) begin
      q0 <= q1;
    end
    if (push && (count == 2'd1) && !pop) begin
      q1 <= res;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/can_interval_intrusion_detector_top.sv =====
// CAN interval intrusion detector.
// Input stream s_*: one transaction is one item; s_tuser says load (1) or
// frame (0). A load writes identifier and minimum interval into a table entry
// and clears its seen mark and short count. A frame is matched against the
// table, lowest index first, and the interval since its last arrival counted.
// Output stream m_*: exactly one result transaction per input transaction.
// The table is a row of TABLE_ENTRIES cells; each item walks the row one cell
// per cycle, registered in every cell, and the next item is taken only once
// the last has left the row and the result queue has room.
// A two-deep result queue lets the next item be taken while a result waits;
// with the receiver stalled and two results held, s_tready stays low.
// cfg_*: alert limit register, always ready; write it only while idle.
// Reset (synchronous, rst high) clears every entry's loaded and seen marks and
// counts and sets the alert limit to 10. No clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
module can_interval_intrusion_detector_top import cid_pkg::*; #(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEFAULT
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  // can_id[10:0], timestamp[31:0], entry_slot[5:0], min_interval[31:0], zero pad
  input  wire logic [87:0]      s_tdata,
  // op
  input  wire logic [0:0]       s_tuser,
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  // matched, hit_slot[5:0], interval[31:0], short_count[7:0], alert
  output logic [RES_W-1:0]      m_tdata,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [CNT_W-1:0] cfg_data
);

  cid_token_t              chain [TABLE_ENTRIES+1];
  logic [TABLE_ENTRIES:0]  chain_vld;
  logic                    busy;
  logic                    accept;
  logic                    space;
  logic [CNT_W-1:0]        alert_limit;

  assign accept    = s_tvalid && s_tready;
  assign s_tready  = !busy && space;
  assign cfg_ready = 1'b1;

  // Alert limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      alert_limit <= ALERT_LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      alert_limit <= cfg_data;
    end
  end

  // One item in the row at a time
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (accept) begin
      busy <= 1'b1;
    end else if (chain[TABLE_ENTRIES].valid) begin
      busy <= 1'b0;
    end
  end

  // Token entering the first cell
  always_comb begin
    chain[0].valid        = accept;
    chain[0].op           = s_tuser[0];
    chain[0].can_id       = s_tdata[10:0];
    chain[0].timestamp    = s_tdata[42:11];
    chain[0].entry_slot   = s_tdata[48:43];
    chain[0].min_interval = s_tdata[80:49];
    chain[0].matched      = 1'b0;
    chain[0].hit_slot     = '0;
    chain[0].interval     = '0;
    chain[0].short_count  = '0;
  end

  // Row of table cells
  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    cid_cell #(
      .CELL_INDEX(g)
    ) u_cell (
      .clk    (clk),
      .rst    (rst),
      .tok_in (chain[g]),
      .tok_out(chain[g+1])
    );
  end

  for (genvar v = 0; v <= TABLE_ENTRIES; v++) begin : g_vld
    assign chain_vld[v] = chain[v].valid;
  end

  // Result queue
  cid_outq u_outq (
    .clk        (clk),
    .rst        (rst),
    .tok_in     (chain[TABLE_ENTRIES]),
    .alert_limit(alert_limit),
    .space      (space),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata)
  );

`ifndef NO_ASSERTIONS
  // Never more than one token in the row
  a_one_token: assert property (@(posedge clk) disable iff (rst) $onehot0(chain_vld))
    else $error("more than one token in the cell row");

  // A token leaving the row always finds room in the queue
  a_queue_room: assert property (@(posedge clk) disable iff (rst)
    chain[TABLE_ENTRIES].valid |-> space)
    else $error("result queue overflow");

  // A load never picks up a match on its way through the row
  a_load_clean: assert property (@(posedge clk) disable iff (rst)
    (chain[TABLE_ENTRIES].valid && (chain[TABLE_ENTRIES].op == OP_LOAD)) |->
    (!chain[TABLE_ENTRIES].matched && (chain[TABLE_ENTRIES].interval == '0) &&
     (chain[TABLE_ENTRIES].short_count == '0)))
    else $error("load result not zero");
`endif

endmodule
`default_nettype wire
